// ===== hw/rtl/rbm_pkg.sv =====
package rbm_pkg;

  localparam int MAX_PAGES = 256;
  localparam int PAGE_W    = 9;
  localparam int BANK_W    = 8;
  localparam int ADDR_W    = 16;
  localparam int ROM_W     = 21;
  localparam int OFFS_W    = 13;

  localparam logic [ADDR_W-1:0] ADDR_WIN_BASE = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_RAM_BASE = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_PAIR_LO  = 16'hFFFE;
  localparam logic [ADDR_W-1:0] ADDR_PAIR_HI  = 16'hFFFF;
  localparam int FLAG_BIT = 6;

  localparam logic [PAGE_W-1:0] PAGES_RESET = PAGE_W'(MAX_PAGES);

  typedef struct packed {
    logic [ROM_W-1:0]  rom_address;
    logic              cart_hit;
    logic [BANK_W-1:0] read_byte;
    logic              register_written;
  } result_t;

  function automatic logic [7:0] bit_rev(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rom_bank_mapper_bit_reverse_core.sv =====
// sequence: reads and plain writes pass ST_IDLE then ST_OUT; a single bank write adds ST_DIV,
//   a bank pair write adds ST_DIV, ST_LO and ST_HI; ST_OUT waits while a result is not taken
// one access at a time, as in_ready is high only in ST_IDLE; the bank write cost is set by the
//   8-step restoring remainder on the shared compare-subtract unit plus two pair steps
// reset (rst_n low, synchronous): banks 2,3,4,5, reverse flags clear,
//   page count 256, no result pending
module rom_bank_mapper_bit_reverse_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rbm_pkg::PAGE_W-1:0]   cfg_page_count,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic [rbm_pkg::ADDR_W-1:0]   in_cpu_address,
  input  logic [rbm_pkg::BANK_W-1:0]   in_write_byte,
  input  logic [rbm_pkg::BANK_W-1:0]   in_rom_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rbm_pkg::ROM_W-1:0]    out_rom_address,
  output logic                         out_cart_hit,
  output logic [rbm_pkg::BANK_W-1:0]   out_read_byte,
  output logic                         out_register_written
);
  import rbm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_LO   = 3'd2;
  localparam logic [2:0] ST_HI   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [PAGE_W-1:0] pages_r, pages_nxt;
  logic [BANK_W-1:0] bank_r [4];
  logic [BANK_W-1:0] bank_nxt [4];
  logic              rev_lo_r, rev_lo_nxt;
  logic              rev_hi_r, rev_hi_nxt;
  logic [BANK_W-1:0] rem_r, rem_nxt;
  logic [BANK_W-1:0] dvd_r, dvd_nxt;
  logic [BANK_W-1:0] lo_r, lo_nxt;
  logic              pair_r, pair_nxt;
  logic              pair_hi_r, pair_hi_nxt;
  logic              flag_r, flag_nxt;
  logic [1:0]        win_r, win_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [PAGE_W-1:0] n_eff;
  logic [PAGE_W-1:0] unit_a;
  logic [BANK_W-1:0] unit_r;
  logic [1:0]        acc_win;
  logic              in_win;
  logic              single_wr;
  logic              pair_wr;
  logic              acc_rev;
  result_t           acc_res;

  rbm_csub u_csub (
    .a (unit_a),
    .n (n_eff),
    .r (unit_r)
  );

  assign cfg_ready            = 1'b1;
  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_rom_address      = out_r.rom_address;
  assign out_cart_hit         = out_r.cart_hit;
  assign out_read_byte        = out_r.read_byte;
  assign out_register_written = out_r.register_written;

  always_comb begin
    if (pages_r == '0) begin
      n_eff = PAGE_W'(1);
    end else if (pages_r > PAGES_RESET) begin
      n_eff = PAGES_RESET;
    end else begin
      n_eff = pages_r;
    end
  end

  // address decode and mapping with the banks as they stand
  always_comb begin
    acc_win   = {~in_cpu_address[14], in_cpu_address[13]};
    in_win    = (in_cpu_address >= ADDR_WIN_BASE) && (in_cpu_address < ADDR_RAM_BASE);
    single_wr = in_opcode && in_win && (in_cpu_address[OFFS_W-1:0] == '0);
    pair_wr   = in_opcode && ((in_cpu_address == ADDR_PAIR_LO) ||
                              (in_cpu_address == ADDR_PAIR_HI));
    acc_rev   = acc_win[1] ? rev_hi_r : rev_lo_r;
    acc_res   = '0;
    if (in_cpu_address < ADDR_WIN_BASE) begin
      acc_res.cart_hit    = 1'b1;
      acc_res.rom_address = ROM_W'(in_cpu_address);
      if (!in_opcode) begin
        acc_res.read_byte = in_rom_byte;
      end
    end else if (in_win) begin
      acc_res.cart_hit    = 1'b1;
      acc_res.rom_address = {bank_r[acc_win], in_cpu_address[OFFS_W-1:0]};
      if (!in_opcode) begin
        acc_res.read_byte = acc_rev ? bit_rev(in_rom_byte) : in_rom_byte;
      end
    end
    acc_res.register_written = single_wr || pair_wr;
  end

  always_comb begin
    unique case (state_r)
      ST_LO:   unit_a = {rem_r, 1'b0};
      ST_HI:   unit_a = PAGE_W'({1'b0, lo_r}) + PAGE_W'(1);
      default: unit_a = {rem_r, dvd_r[BANK_W-1]};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pages_nxt     = pages_r;
    bank_nxt      = bank_r;
    rev_lo_nxt    = rev_lo_r;
    rev_hi_nxt    = rev_hi_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    lo_nxt        = lo_r;
    pair_nxt      = pair_r;
    pair_hi_nxt   = pair_hi_r;
    flag_nxt      = flag_r;
    win_nxt       = win_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (cfg_valid) begin
      pages_nxt = cfg_page_count;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt     = acc_res;
          rem_nxt     = '0;
          dvd_nxt     = in_write_byte;
          cnt_nxt     = '0;
          win_nxt     = acc_win;
          pair_nxt    = pair_wr;
          pair_hi_nxt = in_cpu_address[0];
          flag_nxt    = in_write_byte[FLAG_BIT];
          state_nxt   = (single_wr || pair_wr) ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        rem_nxt = unit_r;
        dvd_nxt = {dvd_r[BANK_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          if (pair_r) begin
            state_nxt = ST_LO;
          end else begin
            bank_nxt[win_r] = unit_r;
            state_nxt       = ST_OUT;
          end
        end
      end
      ST_LO: begin
        lo_nxt    = unit_r;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        if (pair_hi_r) begin
          bank_nxt[2] = lo_r;
          bank_nxt[3] = unit_r;
          rev_hi_nxt  = flag_r;
        end else begin
          bank_nxt[0] = lo_r;
          bank_nxt[1] = unit_r;
          rev_lo_nxt  = flag_r;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pages_r     <= PAGES_RESET;
      bank_r[0]   <= BANK_W'(2);
      bank_r[1]   <= BANK_W'(3);
      bank_r[2]   <= BANK_W'(4);
      bank_r[3]   <= BANK_W'(5);
      rev_lo_r    <= 1'b0;
      rev_hi_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pages_r     <= pages_nxt;
      bank_r      <= bank_nxt;
      rev_lo_r    <= rev_lo_nxt;
      rev_hi_r    <= rev_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    lo_r      <= lo_nxt;
    pair_r    <= pair_nxt;
    pair_hi_r <= pair_hi_nxt;
    flag_r    <= flag_nxt;
    win_r     <= win_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== hw/rtl/rbm_csub.sv =====
module rbm_csub (
  input  logic [rbm_pkg::PAGE_W-1:0] a,
  input  logic [rbm_pkg::PAGE_W-1:0] n,
  output logic [rbm_pkg::BANK_W-1:0] r
);
  import rbm_pkg::*;

  logic [PAGE_W-1:0] diff;

  // conditional subtract step, result below n when a is below 2n
  always_comb begin
    diff = a - n;
    if (a >= n) begin
      r = diff[BANK_W-1:0];
    end else begin
      r = a[BANK_W-1:0];
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rbm_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam logic [ADDR_W-1:0] WIN_STRIDE = 16'h2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [PAGE_W-1:0] cfg_page_count = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_READ;
  logic [ADDR_W-1:0] in_cpu_address = '0;
  logic [BANK_W-1:0] in_write_byte = '0;
  logic [BANK_W-1:0] in_rom_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ROM_W-1:0] out_rom_address;
  logic out_cart_hit;
  logic [BANK_W-1:0] out_read_byte;
  logic out_register_written;

  // mapper state as the testbench sees it
  logic [PAGE_W-1:0] pages_cfg = PAGES_RESET;
  logic [BANK_W-1:0] bank_sel [4] = '{8'd2, 8'd3, 8'd4, 8'd5};
  logic flip_lo = 1'b0;
  logic flip_hi = 1'b0;

  result_t pending_results[$];
  int unsigned bad_results = 0;
  bit calm = 1'b0;

  rom_bank_mapper_bit_reverse_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_page_count       (cfg_page_count),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_cpu_address       (in_cpu_address),
    .in_write_byte        (in_write_byte),
    .in_rom_byte          (in_rom_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_rom_address      (out_rom_address),
    .out_cart_hit         (out_cart_hit),
    .out_read_byte        (out_read_byte),
    .out_register_written (out_register_written)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 9);
  end

  function automatic logic [7:0] mirror_byte(input logic [7:0] b);
    logic [7:0] m;
    for (int k = 0; k < 8; k++) begin
      m[k] = b[7-k];
    end
    return m;
  endfunction

  function automatic result_t map_access(input logic op, input logic [ADDR_W-1:0] addr,
                                         input logic [7:0] wb, input logic [7:0] rb);
    result_t r;
    int unsigned n, d, lo, hi, win;
    logic flip;
    r = '0;
    flip = 1'b0;
    if (addr < ADDR_WIN_BASE) begin
      r.cart_hit = 1'b1;
      r.rom_address = ROM_W'(addr);
    end else if (addr < ADDR_RAM_BASE) begin
      win = int'((addr - ADDR_WIN_BASE) >> OFFS_W);
      r.cart_hit = 1'b1;
      r.rom_address = {bank_sel[win], addr[OFFS_W-1:0]};
      flip = (win < 2) ? flip_lo : flip_hi;
    end
    if (op == OP_READ) begin
      if (r.cart_hit) begin
        r.read_byte = flip ? mirror_byte(rb) : rb;
      end
    end else begin
      n = (pages_cfg == 0) ? 1 : ((pages_cfg > MAX_PAGES) ? MAX_PAGES : pages_cfg);
      d = wb % n;
      if (addr >= ADDR_WIN_BASE && addr < ADDR_RAM_BASE && addr[OFFS_W-1:0] == '0) begin
        bank_sel[int'((addr - ADDR_WIN_BASE) >> OFFS_W)] = BANK_W'(d);
        r.register_written = 1'b1;
      end else if (addr == ADDR_PAIR_LO || addr == ADDR_PAIR_HI) begin
        lo = (d * 2) % n;
        hi = (lo + 1) % n;
        if (addr == ADDR_PAIR_LO) begin
          bank_sel[0] = BANK_W'(lo);
          bank_sel[1] = BANK_W'(hi);
          flip_lo = wb[FLAG_BIT];
        end else begin
          bank_sel[2] = BANK_W'(lo);
          bank_sel[3] = BANK_W'(hi);
          flip_hi = wb[FLAG_BIT];
        end
        r.register_written = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (bad_results < 10) begin
          $display("unexpected result: addr %h hit %b byte %h reg %b",
                   out_rom_address, out_cart_hit, out_read_byte, out_register_written);
        end
        bad_results++;
      end else begin
        want = pending_results.pop_front();
        if (want.rom_address !== out_rom_address || want.cart_hit !== out_cart_hit ||
            want.read_byte !== out_read_byte ||
            want.register_written !== out_register_written) begin
          if (bad_results < 10) begin
            $display("mismatch: expected addr %h hit %b byte %h reg %b, got addr %h hit %b byte %h reg %b",
                     want.rom_address, want.cart_hit, want.read_byte, want.register_written,
                     out_rom_address, out_cart_hit, out_read_byte, out_register_written);
          end
          bad_results++;
        end
      end
    end
  end

  task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [7:0] wb, input logic [7:0] rb);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_cpu_address <= addr;
    in_write_byte <= wb;
    in_rom_byte <= rb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(map_access(op, addr, wb, rb));
  endtask

  task automatic set_page_count(input logic [PAGE_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_page_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pages_cfg = value;
  endtask

  task automatic test_reset_map();
    send_access(OP_READ, 16'h0000, 8'h00, 8'h00);
    send_access(OP_READ, 16'h3FFF, 8'hFF, 8'hFF);
    send_access(OP_READ, 16'h4000, 8'h00, 8'h01);
    send_access(OP_READ, 16'h5FFF, 8'h00, 8'h80);
    send_access(OP_READ, 16'h6000, 8'h00, 8'hA5);
    send_access(OP_READ, 16'h8000, 8'h00, 8'h3C);
    send_access(OP_READ, 16'hA000, 8'h00, 8'h0F);
    send_access(OP_READ, 16'hBFFF, 8'h00, 8'hF0);
    send_access(OP_READ, 16'hC000, 8'h00, 8'hFF);
    send_access(OP_READ, 16'hFFFF, 8'h00, 8'hFF);
  endtask

  task automatic test_register_writes();
    send_access(OP_WRITE, 16'h4000, 8'hFF, 8'h00);
    send_access(OP_WRITE, 16'h6000, 8'h00, 8'h00);
    // same value again still counts as a register write
    send_access(OP_WRITE, 16'h6000, 8'h00, 8'h00);
    send_access(OP_WRITE, 16'h8000, 8'h80, 8'h00);
    send_access(OP_WRITE, 16'hA000, 8'h7F, 8'h00);
    send_access(OP_WRITE, ADDR_PAIR_LO, 8'h7F, 8'h00);
    send_access(OP_READ, 16'h4123, 8'h00, 8'h01);
    send_access(OP_READ, 16'h7FFF, 8'h00, 8'h0F);
    send_access(OP_READ, 16'h1234, 8'h00, 8'h01);
    send_access(OP_WRITE, ADDR_PAIR_HI, 8'hC0, 8'h00);
    send_access(OP_READ, 16'hBFFF, 8'h00, 8'hF0);
    send_access(OP_WRITE, ADDR_PAIR_LO, 8'h00, 8'h00);
    send_access(OP_READ, 16'h5000, 8'h00, 8'h0E);
    send_access(OP_WRITE, 16'hC000, 8'hFF, 8'h00);
    send_access(OP_WRITE, 16'h4001, 8'h12, 8'h00);
    send_access(OP_WRITE, 16'h0000, 8'h55, 8'h00);
  endtask

  task automatic test_random_traffic(input logic [PAGE_W-1:0] pages, input int count,
                                     input bit no_gaps);
    logic op;
    logic [ADDR_W-1:0] addr;
    int unsigned pick;
    set_page_count(pages);
    calm = no_gaps;
    repeat (count) begin
      pick = $urandom_range(99);
      op = 1'($urandom_range(1));
      if (pick < 15) begin
        addr = 16'($urandom_range(16'h3FFF, 0));
      end else if (pick < 45) begin
        op = OP_READ;
        addr = 16'($urandom_range(16'hBFFF, 16'h4000));
      end else if (pick < 70) begin
        op = OP_WRITE;
        pick = $urandom_range(5);
        if (pick < 4) begin
          addr = ADDR_WIN_BASE + 16'(pick) * WIN_STRIDE;
        end else begin
          addr = (pick == 4) ? ADDR_PAIR_LO : ADDR_PAIR_HI;
        end
      end else if (pick < 80) begin
        op = OP_WRITE;
        addr = 16'($urandom_range(16'hBFFF, 16'h4000));
      end else if (pick < 90) begin
        addr = 16'($urandom_range(16'hFFFF, 16'hC000));
      end else begin
        addr = 16'($urandom);
      end
      send_access(op, addr, 8'($urandom), 8'($urandom));
    end
    calm = 1'b0;
  endtask

  task automatic test_page_counts();
    logic [PAGE_W-1:0] sizes [11] = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd2, 9'd3, 9'd7,
                                      9'd100, 9'd255, 9'd257, 9'd128};
    test_random_traffic(sizes[0], 150, 1'b1);
    for (int k = 1; k < 11; k++) begin
      test_random_traffic(sizes[k], 100, 1'b0);
    end
    repeat (2) begin
      test_random_traffic(PAGE_W'($urandom_range(511, 1)), 100, 1'b0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_map();
    test_register_writes();
    test_page_counts();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
